// ===== sv/rls_pkg.sv =====
// ----------------------------------------------------------------------------
// rls_pkg
// Shared widths, codes and reset values for the refill level sequencer.
// ----------------------------------------------------------------------------
package rls_pkg;

	// Timing base and widths
	localparam int TICKS_PER_SECOND = 1000;
	localparam int DELAY_W          = 15;
	localparam int ELAPSED_W        = 25;
	localparam int CFG_W            = DELAY_W;
	localparam int CFG_IDX_W        = 2;
	localparam int MODE_W           = 3;
	localparam int STATUS_W         = 2;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_HIGH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LOW      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT        = 2'd3;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DEBOUNCE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REFILL   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_OVERRUN  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_STEP      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FAULT     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_SENSOR = 2'd2;

	// Reset delays in seconds
	localparam logic [DELAY_W-1:0] DELAY_HIGH_RESET = 15'd3;
	localparam logic [DELAY_W-1:0] DELAY_LOW_RESET  = 15'd10;
	localparam logic [DELAY_W-1:0] TIMEOUT_RESET    = 15'd30;

	// Convert seconds to a tick limit (constant multiply, fits in ELAPSED_W)
	function automatic logic [ELAPSED_W-1:0] sec_to_ticks(input logic [DELAY_W-1:0] sec);
		logic [ELAPSED_W-1:0] ticks;
		ticks = ELAPSED_W'(ELAPSED_W'(sec) * ELAPSED_W'(TICKS_PER_SECOND));
		return ticks;
	endfunction

	// Result of one item
	typedef struct packed {
		logic                pump_on;
		logic [MODE_W-1:0]   mode;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ===== sv/refill_level_sequencer.sv =====
// ----------------------------------------------------------------------------
// refill_level_sequencer
// Water level refill sequencer: debounce, refill, overrun and timeout fault,
// stepped by one millisecond tick per input item.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------
//  in      | in_valid / in_stall        | req_type, level_high
//  out     | out_valid / out_stall      | pump_on, mode, status
//  cfg     | cfg_we (no wait)           | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each accepted result is
// registered. The step is one pass of transition logic from the state
// registers into the result register; tick limits are precomputed at
// configuration writes. A two-entry output buffer (result register plus
// skid) keeps input flowing while out_stall is high; in_stall rises only
// when both entries are full. Reset clears state and loads default delays.
//
module refill_level_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rls_pkg::CFG_W-1:0]     cfg_data,
	// input items
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic                         level_high,
	// result items
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         pump_on,
	output logic [rls_pkg::MODE_W-1:0]    mode,
	output logic [rls_pkg::STATUS_W-1:0]  status
);

	// Configuration registers
	logic                              sensor_en_q;
	logic [rls_pkg::ELAPSED_W-1:0]     limit_high_q;
	logic [rls_pkg::ELAPSED_W-1:0]     limit_low_q;
	logic [rls_pkg::ELAPSED_W-1:0]     limit_timeout_q;

	// Sequencer state
	logic [rls_pkg::MODE_W-1:0]        mode_q;
	logic [rls_pkg::ELAPSED_W-1:0]     elapsed_q;
	logic                              pump_q;

	// Next state and result
	logic [rls_pkg::MODE_W-1:0]        mode_n;
	logic [rls_pkg::ELAPSED_W-1:0]     elapsed_n;
	logic [rls_pkg::ELAPSED_W-1:0]     elapsed_inc;
	logic                              pump_n;
	logic [rls_pkg::STATUS_W-1:0]      status_n;
	rls_pkg::result_t                  result_n;

	// Output buffer
	logic                              out_valid_q;
	logic                              skid_valid_q;
	rls_pkg::result_t                  out_q;
	rls_pkg::result_t                  skid_q;

	logic                              in_accept;
	logic                              out_take;

	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;

	// Write configuration; delays are kept as tick limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_en_q     <= 1'b0;
			limit_high_q    <= rls_pkg::sec_to_ticks(rls_pkg::DELAY_HIGH_RESET);
			limit_low_q     <= rls_pkg::sec_to_ticks(rls_pkg::DELAY_LOW_RESET);
			limit_timeout_q <= rls_pkg::sec_to_ticks(rls_pkg::TIMEOUT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				rls_pkg::REG_SENSOR_ENABLED: sensor_en_q     <= cfg_data[0];
				rls_pkg::REG_DELAY_HIGH:     limit_high_q    <= rls_pkg::sec_to_ticks(cfg_data);
				rls_pkg::REG_DELAY_LOW:      limit_low_q     <= rls_pkg::sec_to_ticks(cfg_data);
				rls_pkg::REG_TIMEOUT:        limit_timeout_q <= rls_pkg::sec_to_ticks(cfg_data);
				default: ;
			endcase
		end
	end

	// Advance the elapsed counter, saturating
	assign elapsed_inc = (elapsed_q == rls_pkg::ELAPSED_MAX) ? elapsed_q
		: elapsed_q + rls_pkg::ELAPSED_W'(1);

	// Step the sequencer for one item
	always_comb begin
		mode_n    = mode_q;
		elapsed_n = elapsed_q;
		pump_n    = pump_q;
		status_n  = rls_pkg::STATUS_STEP;
		if (req_type) begin
			mode_n = rls_pkg::MODE_IDLE;
		end else begin
			elapsed_n = elapsed_inc;
			if (!sensor_en_q) begin
				status_n = rls_pkg::STATUS_NO_SENSOR;
			end else begin
				case (mode_q)
					rls_pkg::MODE_IDLE: begin
						pump_n = 1'b0;
						if (level_high) begin
							mode_n    = rls_pkg::MODE_DEBOUNCE;
							elapsed_n = '0;
						end
					end
					rls_pkg::MODE_DEBOUNCE: begin
						if (!level_high) begin
							mode_n = rls_pkg::MODE_IDLE;
						end else if (elapsed_inc > limit_high_q) begin
							pump_n    = 1'b1;
							elapsed_n = '0;
							mode_n    = rls_pkg::MODE_REFILL;
						end
					end
					rls_pkg::MODE_REFILL: begin
						if (!level_high) begin
							mode_n    = rls_pkg::MODE_OVERRUN;
							elapsed_n = '0;
						end else if (elapsed_inc > limit_timeout_q) begin
							mode_n = rls_pkg::MODE_FAULT;
							pump_n = 1'b0;
						end
					end
					rls_pkg::MODE_OVERRUN: begin
						if (level_high) begin
							mode_n = rls_pkg::MODE_REFILL;
						end else if (elapsed_inc > limit_low_q) begin
							mode_n = rls_pkg::MODE_IDLE;
							pump_n = 1'b0;
						end
					end
					default: begin
						status_n = rls_pkg::STATUS_FAULT;
					end
				endcase
			end
		end
		result_n.pump_on = pump_n;
		result_n.mode    = mode_n;
		result_n.status  = status_n;
	end

	// Update state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= rls_pkg::MODE_IDLE;
			elapsed_q <= '0;
			pump_q    <= 1'b0;
		end else if (in_accept) begin
			mode_q    <= mode_n;
			elapsed_q <= elapsed_n;
			pump_q    <= pump_n;
		end
	end

	// Output buffer control: result register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_accept;
				end
			end else if (in_accept) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// Output buffer payload
	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_accept) begin
				out_q <= result_n;
			end
		end else if (in_accept) begin
			if (out_valid_q) begin
				skid_q <= result_n;
			end else begin
				out_q <= result_n;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pump_on   = out_q.pump_on;
	assign mode      = out_q.mode;
	assign status    = out_q.status;

	// Skid entry is only used behind a full result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid while result register empty");

	// A clear request always returns the sequencer to idle
	a_clear_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && req_type) |=> (mode_q == rls_pkg::MODE_IDLE))
		else $error("clear request did not return to idle");

	// Pump stays off while debouncing
	a_debounce_pump_off: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == rls_pkg::MODE_DEBOUNCE) |-> !pump_q)
		else $error("pump on during debounce");

	// Pump stays off in timeout fault
	a_fault_pump_off: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == rls_pkg::MODE_FAULT) |-> !pump_q)
		else $error("pump on during timeout fault");

endmodule
